### src/rqs_pkg.sv
// Shared types and constants of the three-level ready queue.
// Used by rqs_sorted and three_level_ready_queue_top; depends on nothing.
package rqs_pkg;

  localparam int unsigned LEVEL_DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(LEVEL_DEPTH);
  localparam int unsigned CNT_W = $clog2(LEVEL_DEPTH + 1);
  localparam int unsigned ID_W = 8;
  localparam int unsigned KEY_W = 16;
  localparam int unsigned PRIO_W = 8;

  localparam logic [PRIO_W-1:0] LOW_LIMIT_RST = 8'd50;
  localparam logic [PRIO_W-1:0] HIGH_LIMIT_RST = 8'd100;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DISPATCH = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [1:0] LVL_TOP = 2'd0;
  localparam logic [1:0] LVL_MID = 2'd1;
  localparam logic [1:0] LVL_FIFO = 2'd2;

  localparam logic CFG_LOW_LIMIT = 1'b0;
  localparam logic CFG_HIGH_LIMIT = 1'b1;

  typedef struct packed {
    logic             ins;
    logic             pop;
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
  } lvl_cmd_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] count;
    logic [ID_W-1:0]  head_id;
  } lvl_stat_t;

endpackage

### src/rqs_sorted.sv
// One sorted level: ascending key order, ties in arrival order.
// Insert scans then shifts one entry per cycle; pop shifts one entry per cycle.
// Depends on rqs_pkg.
module rqs_sorted (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rqs_pkg::lvl_cmd_t    cmd_i,
  output rqs_pkg::lvl_stat_t   stat_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_POP   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [rqs_pkg::CNT_W-1:0] count_q, count_d;
  logic [rqs_pkg::CNT_W-1:0] ptr_q, ptr_d;
  logic [rqs_pkg::CNT_W-1:0] pos_q, pos_d;
  logic [rqs_pkg::ID_W-1:0]  id_q, id_d;
  logic [rqs_pkg::KEY_W-1:0] key_q, key_d;

  logic [rqs_pkg::ID_W-1:0]  mem_id  [rqs_pkg::LEVEL_DEPTH];
  logic [rqs_pkg::KEY_W-1:0] mem_key [rqs_pkg::LEVEL_DEPTH];

  logic [rqs_pkg::CNT_W-1:0] ptr_m1;
  logic [rqs_pkg::IDX_W-1:0] rd_addr;
  logic [rqs_pkg::ID_W-1:0]  rd_id;
  logic [rqs_pkg::KEY_W-1:0] rd_key;
  logic                      we;
  logic [rqs_pkg::IDX_W-1:0] wa;
  logic [rqs_pkg::ID_W-1:0]  wid;
  logic [rqs_pkg::KEY_W-1:0] wkey;

  assign ptr_m1 = ptr_q - rqs_pkg::CNT_W'(1);

  always_comb begin
    case (state_q)
      S_SCAN:  rd_addr = ptr_q[rqs_pkg::IDX_W-1:0];
      S_SHIFT: rd_addr = ptr_m1[rqs_pkg::IDX_W-1:0];
      S_POP:   rd_addr = ptr_q[rqs_pkg::IDX_W-1:0];
      default: rd_addr = '0;
    endcase
  end

  assign rd_id  = mem_id[rd_addr];
  assign rd_key = mem_key[rd_addr];

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ptr_d   = ptr_q;
    pos_d   = pos_q;
    id_d    = id_q;
    key_d   = key_q;
    we      = 1'b0;
    wa      = '0;
    wid     = rd_id;
    wkey    = rd_key;
    case (state_q)
      S_IDLE: begin
        if (cmd_i.ins) begin
          id_d    = cmd_i.id;
          key_d   = cmd_i.key;
          ptr_d   = '0;
          state_d = S_SCAN;
        end else if (cmd_i.pop) begin
          ptr_d   = rqs_pkg::CNT_W'(1);
          state_d = S_POP;
        end
      end
      S_SCAN: begin
        // advance past entries whose key does not exceed the new one
        if (ptr_q < count_q && rd_key <= key_q) begin
          ptr_d = ptr_q + rqs_pkg::CNT_W'(1);
        end else begin
          pos_d   = ptr_q;
          ptr_d   = count_q;
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        we = 1'b1;
        if (ptr_q > pos_q) begin
          wa    = ptr_q[rqs_pkg::IDX_W-1:0];
          ptr_d = ptr_m1;
        end else begin
          wa      = pos_q[rqs_pkg::IDX_W-1:0];
          wid     = id_q;
          wkey    = key_q;
          count_d = count_q + rqs_pkg::CNT_W'(1);
          state_d = S_IDLE;
        end
      end
      S_POP: begin
        if (ptr_q < count_q) begin
          we    = 1'b1;
          wa    = ptr_m1[rqs_pkg::IDX_W-1:0];
          ptr_d = ptr_q + rqs_pkg::CNT_W'(1);
        end else begin
          count_d = count_q - rqs_pkg::CNT_W'(1);
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ptr_q   <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ptr_q   <= ptr_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    key_q <= key_d;
    if (we) begin
      mem_id[wa]  <= wid;
      mem_key[wa] <= wkey;
    end
  end

  assign stat_o.busy    = (state_q != S_IDLE);
  assign stat_o.count   = count_q;
  assign stat_o.head_id = mem_id[0];

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= rqs_pkg::CNT_W'(rqs_pkg::LEVEL_DEPTH))
    else $error("level count above depth");
  a_no_ins_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && cmd_i.ins) |-> count_q < rqs_pkg::CNT_W'(rqs_pkg::LEVEL_DEPTH))
    else $error("insert into full level");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && cmd_i.pop) |-> count_q != '0)
    else $error("pop from empty level");
  a_cmd_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.ins || cmd_i.pop) |-> state_q == S_IDLE)
    else $error("command while busy");
`endif

endmodule

### src/three_level_ready_queue_top.sv
// Three-level ready queue: decode, FIFO level, limits, timer and preempt flags.
// Two rqs_sorted instances hold the top (burst) and middle (priority) levels.
// Depends on rqs_pkg and rqs_sorted.
// The result is registered when the item is accepted.
// Peek, FIFO ops and rejected inserts leave the input ready for the next item;
// a sorted insert or dispatch holds s_axis_tready_o low until its level sequencer,
// one compare/move step per cycle, is idle again; a stalled output also holds it low.
// Reset: all levels empty, timer and preempt flags clear, limits 50 and 100.
module three_level_ready_queue_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // opcode[1:0], task_id[9:2], task_priority[17:10], burst_estimate[33:18],
  // is_running_task[34], zero fill above
  input  logic [39:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // status[1:0], chosen_id[9:2], chosen_level[11:10], slice_timer_on[12],
  // preempt_request[13], zero fill above
  output logic [15:0] m_axis_tdata_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  logic [1:0]                 opcode;
  logic [rqs_pkg::ID_W-1:0]   task_id;
  logic [rqs_pkg::PRIO_W-1:0] task_priority;
  logic [rqs_pkg::KEY_W-1:0]  burst_estimate;
  logic                       is_running_task;

  assign opcode          = s_axis_tdata_i[1:0];
  assign task_id         = s_axis_tdata_i[9:2];
  assign task_priority   = s_axis_tdata_i[17:10];
  assign burst_estimate  = s_axis_tdata_i[33:18];
  assign is_running_task = s_axis_tdata_i[34];

  logic [rqs_pkg::PRIO_W-1:0] low_limit_q, high_limit_q;
  logic                       timer_q, timer_d, preempt_q, preempt_d;
  logic                       out_valid_q;
  logic [13:0]                out_q;
  rqs_pkg::lvl_cmd_t          top_cmd_q, top_cmd_d, mid_cmd_q, mid_cmd_d;
  rqs_pkg::lvl_stat_t         top_stat, mid_stat;

  logic [rqs_pkg::ID_W-1:0]  fifo_mem [rqs_pkg::LEVEL_DEPTH];
  logic [rqs_pkg::IDX_W-1:0] fifo_head_q, fifo_head_d;
  logic [rqs_pkg::CNT_W-1:0] fifo_count_q, fifo_count_d;
  logic [rqs_pkg::CNT_W-1:0] fifo_tail_sum;
  logic                      fifo_we;

  logic                      accept;
  logic [1:0]                status, clevel;
  logic [rqs_pkg::ID_W-1:0]  cid;
  logic                      full_cnt_top, full_cnt_mid, full_cnt_fifo;

  assign cfg_ready_o = 1'b1;

  assign s_axis_tready_o = !top_stat.busy && !mid_stat.busy && !top_cmd_q.ins
                           && !top_cmd_q.pop && !mid_cmd_q.ins && !mid_cmd_q.pop
                           && (!out_valid_q || m_axis_tready_i);
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  assign full_cnt_top  = (top_stat.count == rqs_pkg::CNT_W'(rqs_pkg::LEVEL_DEPTH));
  assign full_cnt_mid  = (mid_stat.count == rqs_pkg::CNT_W'(rqs_pkg::LEVEL_DEPTH));
  assign full_cnt_fifo = (fifo_count_q == rqs_pkg::CNT_W'(rqs_pkg::LEVEL_DEPTH));
  assign fifo_tail_sum = rqs_pkg::CNT_W'(fifo_head_q) + fifo_count_q;

  always_comb begin
    status       = rqs_pkg::ST_OK;
    clevel       = rqs_pkg::LVL_TOP;
    cid          = '0;
    timer_d      = timer_q;
    preempt_d    = preempt_q;
    fifo_head_d  = fifo_head_q;
    fifo_count_d = fifo_count_q;
    fifo_we      = 1'b0;
    top_cmd_d    = '0;
    mid_cmd_d    = '0;
    top_cmd_d.id  = task_id;
    top_cmd_d.key = burst_estimate;
    mid_cmd_d.id  = task_id;
    // descending priority becomes ascending on the inverted priority
    mid_cmd_d.key = {{(rqs_pkg::KEY_W - rqs_pkg::PRIO_W){1'b0}}, ~task_priority};
    case (opcode)
      rqs_pkg::OP_INSERT: begin
        cid = task_id;
        if (task_priority < low_limit_q) begin
          clevel = rqs_pkg::LVL_FIFO;
          if (full_cnt_fifo) begin
            status = rqs_pkg::ST_FULL;
          end else begin
            fifo_we      = 1'b1;
            fifo_count_d = fifo_count_q + rqs_pkg::CNT_W'(1);
          end
        end else if (task_priority < high_limit_q) begin
          clevel = rqs_pkg::LVL_MID;
          if (full_cnt_mid) begin
            status = rqs_pkg::ST_FULL;
          end else begin
            mid_cmd_d.ins = 1'b1;
            if (!is_running_task) preempt_d = 1'b1;
          end
        end else begin
          clevel = rqs_pkg::LVL_TOP;
          if (full_cnt_top) begin
            status = rqs_pkg::ST_FULL;
          end else begin
            top_cmd_d.ins = 1'b1;
            if (!is_running_task) preempt_d = 1'b1;
          end
        end
      end
      rqs_pkg::OP_DISPATCH, rqs_pkg::OP_PEEK: begin
        if (top_stat.count != '0) begin
          cid    = top_stat.head_id;
          clevel = rqs_pkg::LVL_TOP;
          if (opcode == rqs_pkg::OP_DISPATCH) begin
            top_cmd_d.pop = 1'b1;
            timer_d       = 1'b0;
          end
        end else if (mid_stat.count != '0) begin
          cid    = mid_stat.head_id;
          clevel = rqs_pkg::LVL_MID;
          if (opcode == rqs_pkg::OP_DISPATCH) begin
            mid_cmd_d.pop = 1'b1;
            timer_d       = 1'b0;
          end
        end else if (fifo_count_q != '0) begin
          cid    = fifo_mem[fifo_head_q];
          clevel = rqs_pkg::LVL_FIFO;
          if (opcode == rqs_pkg::OP_DISPATCH) begin
            fifo_head_d  = fifo_head_q + rqs_pkg::IDX_W'(1);
            fifo_count_d = fifo_count_q - rqs_pkg::CNT_W'(1);
            timer_d      = 1'b1;
          end
        end else begin
          status = rqs_pkg::ST_EMPTY;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_limit_q  <= rqs_pkg::LOW_LIMIT_RST;
      high_limit_q <= rqs_pkg::HIGH_LIMIT_RST;
      timer_q      <= 1'b0;
      preempt_q    <= 1'b0;
      fifo_head_q  <= '0;
      fifo_count_q <= '0;
      out_valid_q  <= 1'b0;
      top_cmd_q    <= '0;
      mid_cmd_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          rqs_pkg::CFG_LOW_LIMIT:  low_limit_q  <= cfg_data_i;
          rqs_pkg::CFG_HIGH_LIMIT: high_limit_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        timer_q      <= timer_d;
        preempt_q    <= preempt_d;
        fifo_head_q  <= fifo_head_d;
        fifo_count_q <= fifo_count_d;
        out_valid_q  <= 1'b1;
        top_cmd_q    <= top_cmd_d;
        mid_cmd_q    <= mid_cmd_d;
      end else begin
        // level commands last one cycle
        top_cmd_q.ins <= 1'b0;
        top_cmd_q.pop <= 1'b0;
        mid_cmd_q.ins <= 1'b0;
        mid_cmd_q.pop <= 1'b0;
        if (m_axis_tready_i) out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= {preempt_d, timer_d, clevel, cid, status};
      if (fifo_we) fifo_mem[fifo_tail_sum[rqs_pkg::IDX_W-1:0]] <= task_id;
    end
  end

  rqs_sorted u_top_level (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (top_cmd_q),
    .stat_o (top_stat)
  );

  rqs_sorted u_mid_level (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mid_cmd_q),
    .stat_o (mid_stat)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_q};

`ifndef ASSERT_OFF
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_count_q <= rqs_pkg::CNT_W'(rqs_pkg::LEVEL_DEPTH))
    else $error("fifo count above depth");
  a_one_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({top_cmd_q.ins, top_cmd_q.pop, mid_cmd_q.ins, mid_cmd_q.pop}) <= 1)
    else $error("more than one level command");
  a_preempt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    preempt_q |=> preempt_q)
    else $error("preempt flag cleared");
`endif

endmodule
